/* sv/caustic_light_pixel_modulator_defines.svh */
// Assertion macros shared by the caustic light pixel modulator modules
`ifndef CAUSTIC_LIGHT_PIXEL_MODULATOR_DEFINES_SVH
`define CAUSTIC_LIGHT_PIXEL_MODULATOR_DEFINES_SVH

// same-cycle implication, checked outside reset
`define CLPM_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("clpm: same-cycle check failed");

// next-cycle implication, checked outside reset
`define CLPM_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("clpm: next-cycle check failed");

`endif

/* sv/clpm_pkg.sv */
// Shared types, constants and tables of the caustic light pixel modulator
package clpm_pkg;

  localparam int COORD_W   = 12;
  localparam int SIN_DEPTH = 1024;
  localparam int SIN_IDX_W = $clog2(SIN_DEPTH);
  localparam int QTR_DEPTH = SIN_DEPTH / 4;
  localparam int QTR_W     = $clog2(QTR_DEPTH);
  localparam int PH_W      = 24;
  localparam int SCALE_W   = 20;
  localparam int NRM_W     = COORD_W + SCALE_W;
  localparam int KONST_W   = 24;
  localparam int FT_W      = 32;
  localparam int SMOOTH_W  = 7;
  localparam int CFG_IDX_W = 4;
  localparam int CFG_W     = 32;
  localparam int EXP_W     = 18;
  localparam int FRAC_W    = 16;
  localparam int LG_W      = 21;
  localparam int M_W       = 31;
  localparam int K_W       = 17;

  localparam int PH_LAT = 3;
  localparam int WV_LAT = 5;
  localparam int PW_LAT = 36;
  localparam int CH_LAT = 3;
  localparam int TOTAL_LAT = PH_LAT + WV_LAT + PW_LAT + CH_LAT;

  localparam logic [CFG_IDX_W-1:0] CFG_INV_X  = 4'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_INV_Y  = 4'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SMOOTH = 4'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_FTIME  = 4'd3;

  localparam logic [SCALE_W-1:0]  RST_INV_SCALE = 20'd20972;
  localparam logic [SMOOTH_W-1:0] RST_SMOOTH    = 7'd50;

  localparam logic [KONST_W-1:0] K_A   = 24'd5340354;
  localparam logic [KONST_W-1:0] K_C_X = 24'd9879654;
  localparam logic [KONST_W-1:0] K_C_Y = 24'd6141407;
  localparam logic [KONST_W-1:0] K_D_X = 24'd13617902;
  localparam logic [KONST_W-1:0] K_D_Y = 24'd10680707;
  localparam logic [KONST_W-1:0] T_A   = 24'd1335088;
  localparam logic [KONST_W-1:0] T_B   = 24'd934562;
  localparam logic [KONST_W-1:0] T_C   = 24'd1735615;
  localparam logic [KONST_W-1:0] T_D   = 24'd2803686;

  localparam logic [PH_W-1:0] QUARTER_TURN = 24'h400000;
  localparam logic [63:0]     HALF_PI_Q30  = 64'd1686629713;
  localparam logic [M_W-1:0]  ONE_Q30      = 31'd1073741824;
  localparam logic [33:0]     WAVE_OFS     = 34'd1879048192;
  localparam logic [15:0]     RECIP7       = 16'd37449;
  localparam logic [16:0]     BLUE_GAIN    = 17'd72090;

  typedef struct packed {
    logic       vld;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } clpm_tag_t;

  typedef logic [14:0]      sin_tab_t [QTR_DEPTH];
  typedef logic [EXP_W-1:0] exp_tab_t [2**SMOOTH_W];
  typedef logic [29:0]      e2_tab_t  [FRAC_W];

  function automatic logic [14:0] sin_mag(input int unsigned jj);
    logic [63:0] th;
    logic [63:0] pos;
    logic [63:0] neg;
    logic [63:0] term;
    logic [63:0] v;
    th   = (HALF_PI_Q30 * 64'(jj)) >> QTR_W;
    pos  = th;
    neg  = '0;
    term = th;
    term = (((term * th) >> 30) * th) >> 30; term = term / 6;   neg += term;
    term = (((term * th) >> 30) * th) >> 30; term = term / 20;  pos += term;
    term = (((term * th) >> 30) * th) >> 30; term = term / 42;  neg += term;
    term = (((term * th) >> 30) * th) >> 30; term = term / 72;  pos += term;
    term = (((term * th) >> 30) * th) >> 30; term = term / 110; neg += term;
    term = (((term * th) >> 30) * th) >> 30; term = term / 156; pos += term;
    term = (((term * th) >> 30) * th) >> 30; term = term / 210; neg += term;
    term = (((term * th) >> 30) * th) >> 30; term = term / 272; pos += term;
    v = (pos > neg) ? pos - neg : 64'd0;
    v = (v + 64'd16384) >> 15;
    if (v > 64'd32767) v = 64'd32767;
    return v[14:0];
  endfunction

  function automatic sin_tab_t build_sin_tab();
    sin_tab_t t;
    for (int i = 0; i < QTR_DEPTH; i++) t[i] = sin_mag(i);
    return t;
  endfunction

  localparam sin_tab_t    SIN_TAB  = build_sin_tab();
  localparam logic [14:0] SIN_PEAK = sin_mag(QTR_DEPTH);

  function automatic logic signed [15:0] sine_of(input logic [PH_W-1:0] ph);
    logic [SIN_IDX_W-1:0] idx;
    logic [1:0]           quad;
    logic [QTR_W-1:0]     j;
    logic [QTR_W:0]       r;
    logic [14:0]          mag;
    idx  = ph[PH_W-1 -: SIN_IDX_W];
    quad = idx[SIN_IDX_W-1 -: 2];
    j    = idx[QTR_W-1:0];
    r    = quad[0] ? (QTR_W+1)'(QTR_DEPTH) - {1'b0, j} : {1'b0, j};
    mag  = r[QTR_W] ? SIN_PEAK : SIN_TAB[r[QTR_W-1:0]];
    return quad[1] ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
  endfunction

  function automatic exp_tab_t build_exp_tab();
    exp_tab_t    t;
    int unsigned p;
    for (int i = 0; i < 2**SMOOTH_W; i++) begin
      p    = (i > 100) ? 100 : i;
      t[i] = EXP_W'(((150 - p) * 65536 + 25) / 50);
    end
    return t;
  endfunction

  localparam exp_tab_t EXP_TAB = build_exp_tab();

  localparam e2_tab_t E2_TAB = '{
    30'd759250125,  30'd902905651,  30'd984625594,  30'd1028218693,
    30'd1050733751, 30'd1062175491, 30'd1067942999, 30'd1070838486,
    30'd1072289173, 30'd1073015252, 30'd1073378477, 30'd1073560135,
    30'd1073650976, 30'd1073696399, 30'd1073719111, 30'd1073730468
  };

endpackage

/* sv/caustic_light_pixel_modulator.sv */
// Top level of the caustic light pixel modulator: registers, pipeline and channel scaling
//
//  channel  | handshake          | payload
//  ---------+--------------------+---------------------------------------------
//  input    | start / busy       | in_pix_x, in_pix_y, in_red, in_green, in_blue
//  result   | out_valid strobe   | out_red, out_green, out_blue
//  config   | cfg_we             | cfg_idx, cfg_wdata
//
// One pixel per clock; each result transfers once its input has passed the phase, wave, power and channel stages.
// The depth is set by the 16 squaring steps of the log2 and the 16 product steps
// of the exp2, each a multiply of at most 31 by 31 bits with its own register.
// busy is high only during reset; synchronous reset empties the pipeline.
// Results are never held back, so nothing in the pipeline stalls.
`include "caustic_light_pixel_modulator_defines.svh"
module caustic_light_pixel_modulator import clpm_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  output logic                 busy,
  input  logic [COORD_W-1:0]   in_pix_x,
  input  logic [COORD_W-1:0]   in_pix_y,
  input  logic [7:0]           in_red,
  input  logic [7:0]           in_green,
  input  logic [7:0]           in_blue,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_idx,
  input  logic [CFG_W-1:0]     cfg_wdata,
  output logic                 out_valid,
  output logic [7:0]           out_red,
  output logic [7:0]           out_green,
  output logic [7:0]           out_blue
);

  logic [SCALE_W-1:0]  inv_x_r, inv_y_r;
  logic [SMOOTH_W-1:0] smooth_r;
  logic [FT_W-1:0]     ftime_r;

  clpm_tag_t       in_tag, ph_tag, wv_tag, pw_tag;
  logic [PH_W-1:0] pa, pb, pc, pd;
  logic [15:0]     base;
  logic [K_W-1:0]  pw_k;

  clpm_tag_t   c1_r, c2_r;
  logic [24:0] rk_r, gk_r, bk_r;
  logic [7:0]  r2_r, g2_r, r2_nxt, g2_nxt;
  logic [41:0] bp_r, bp_nxt;
  logic        ov_r;
  logic [7:0]  or_r, og_r, ob_r, ob_nxt;

  assign busy = !rst_n;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      inv_x_r  <= RST_INV_SCALE;
      inv_y_r  <= RST_INV_SCALE;
      smooth_r <= RST_SMOOTH;
      ftime_r  <= '0;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        CFG_INV_X:  inv_x_r  <= cfg_wdata[SCALE_W-1:0];
        CFG_INV_Y:  inv_y_r  <= cfg_wdata[SCALE_W-1:0];
        CFG_SMOOTH: smooth_r <= cfg_wdata[SMOOTH_W-1:0];
        CFG_FTIME:  ftime_r  <= cfg_wdata[FT_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    in_tag.vld   = start && !busy;
    in_tag.red   = in_red;
    in_tag.green = in_green;
    in_tag.blue  = in_blue;
  end

  clpm_phase u_phase (
    .clk   (clk),
    .rst_n (rst_n),
    .tag_i (in_tag),
    .pix_x (in_pix_x),
    .pix_y (in_pix_y),
    .inv_x (inv_x_r),
    .inv_y (inv_y_r),
    .ftime (ftime_r),
    .tag_o (ph_tag),
    .pa    (pa),
    .pb    (pb),
    .pc    (pc),
    .pd    (pd)
  );

  clpm_wave u_wave (
    .clk   (clk),
    .rst_n (rst_n),
    .tag_i (ph_tag),
    .pa    (pa),
    .pb    (pb),
    .pc    (pc),
    .pd    (pd),
    .tag_o (wv_tag),
    .base  (base)
  );

  clpm_power u_power (
    .clk    (clk),
    .rst_n  (rst_n),
    .tag_i  (wv_tag),
    .base   (base),
    .smooth (smooth_r),
    .tag_o  (pw_tag),
    .k      (pw_k)
  );

  always_ff @(posedge clk) begin
    c1_r <= pw_tag;
    rk_r <= 25'(pw_tag.red) * 25'(pw_k);
    gk_r <= 25'(pw_tag.green) * 25'(pw_k);
    bk_r <= 25'(pw_tag.blue) * 25'(pw_k);
    if (!rst_n) c1_r.vld <= 1'b0;
  end

  assign r2_nxt = (rk_r[24:16] >= 9'd255) ? 8'd255 : rk_r[23:16];
  assign g2_nxt = (gk_r[24:16] >= 9'd255) ? 8'd255 : gk_r[23:16];
  assign bp_nxt = 42'(bk_r) * 42'(BLUE_GAIN);

  always_ff @(posedge clk) begin
    c2_r <= c1_r;
    r2_r <= r2_nxt;
    g2_r <= g2_nxt;
    bp_r <= bp_nxt;
    if (!rst_n) c2_r.vld <= 1'b0;
  end

  assign ob_nxt = (bp_r[41:32] >= 10'd255) ? 8'd255 : bp_r[39:32];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ov_r <= 1'b0;
    end else begin
      ov_r <= c2_r.vld;
    end
    or_r <= r2_r;
    og_r <= g2_r;
    ob_r <= ob_nxt;
  end

  assign out_valid = ov_r;
  assign out_red   = or_r;
  assign out_green = og_r;
  assign out_blue  = ob_r;

  `CLPM_ASSERT_IMP(a_latency, $past(rst_n, TOTAL_LAT), out_valid == $past(start && !busy, TOTAL_LAT))
  `CLPM_ASSERT_IMP(a_dark, out_valid && ($past(pw_k, CH_LAT) == '0),
                   out_red == 8'd0 && out_green == 8'd0 && out_blue == 8'd0)

endmodule

/* sv/clpm_phase.sv */
// Coordinate scaling and wave phase generation, three register stages
`include "caustic_light_pixel_modulator_defines.svh"
module clpm_phase import clpm_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  clpm_tag_t          tag_i,
  input  logic [COORD_W-1:0] pix_x,
  input  logic [COORD_W-1:0] pix_y,
  input  logic [SCALE_W-1:0] inv_x,
  input  logic [SCALE_W-1:0] inv_y,
  input  logic [FT_W-1:0]    ftime,
  output clpm_tag_t          tag_o,
  output logic [PH_W-1:0]    pa,
  output logic [PH_W-1:0]    pb,
  output logic [PH_W-1:0]    pc,
  output logic [PH_W-1:0]    pd
);

  function automatic logic [PH_W-1:0] time_term(input logic [FT_W-1:0] ft,
                                                input logic [KONST_W-1:0] k);
    logic [FT_W+KONST_W-1:0] pr;
    pr = ft * k;
    return pr[16 +: PH_W];
  endfunction

  function automatic logic [PH_W-1:0] coord_term(input logic [NRM_W-1:0] n,
                                                 input logic [KONST_W-1:0] k);
    logic [NRM_W+KONST_W-1:0] pr;
    pr = n * k;
    return pr[20 +: PH_W];
  endfunction

  clpm_tag_t t1_r, t2_r, t3_r;
  logic [NRM_W-1:0] nx_r, ny_r, nx_nxt, ny_nxt;
  logic [PH_W-1:0]  ta_r, tb_r, tc_r, td_r;
  logic [PH_W-1:0]  ta2_r, tb2_r, tc2_r, td2_r;
  logic [PH_W-1:0]  cax_r, cby_r, ccx_r, ccy_r, cdx_r, cdy_r;
  logic [PH_W-1:0]  pa_r, pb_r, pc_r, pd_r;
  logic [PH_W-1:0]  pa_nxt, pb_nxt, pc_nxt, pd_nxt;

  assign nx_nxt = NRM_W'(pix_x) * NRM_W'(inv_x);
  assign ny_nxt = NRM_W'(pix_y) * NRM_W'(inv_y);

  always_ff @(posedge clk) begin
    t1_r <= tag_i;
    t2_r <= t1_r;
    t3_r <= t2_r;
    if (!rst_n) begin
      t1_r.vld <= 1'b0;
      t2_r.vld <= 1'b0;
      t3_r.vld <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    nx_r  <= nx_nxt;
    ny_r  <= ny_nxt;
    ta_r  <= time_term(ftime, T_A);
    tb_r  <= time_term(ftime, T_B);
    tc_r  <= time_term(ftime, T_C);
    td_r  <= time_term(ftime, T_D);
    cax_r <= coord_term(nx_r, K_A);
    cby_r <= coord_term(ny_r, K_A);
    ccx_r <= coord_term(nx_r, K_C_X);
    ccy_r <= coord_term(ny_r, K_C_Y);
    cdx_r <= coord_term(nx_r, K_D_X);
    cdy_r <= coord_term(ny_r, K_D_Y);
    ta2_r <= ta_r;
    tb2_r <= tb_r;
    tc2_r <= tc_r;
    td2_r <= td_r;
    pa_r  <= pa_nxt;
    pb_r  <= pb_nxt;
    pc_r  <= pc_nxt;
    pd_r  <= pd_nxt;
  end

  assign pa_nxt = cax_r + ta2_r;
  assign pb_nxt = cby_r + tb2_r + QUARTER_TURN;
  assign pc_nxt = ccx_r + ccy_r + tc2_r;
  assign pd_nxt = cdx_r - cdy_r + td2_r;

  assign tag_o = t3_r;
  assign pa    = pa_r;
  assign pb    = pb_r;
  assign pc    = pc_r;
  assign pd    = pd_r;

  `CLPM_ASSERT_NXT(a_ph_vld, t1_r.vld, t2_r.vld)

endmodule

/* sv/clpm_wave.sv */
// Sine lookup, wave sum and normalisation to a Q16 base, five register stages
`include "caustic_light_pixel_modulator_defines.svh"
module clpm_wave import clpm_pkg::*; (
  input  logic            clk,
  input  logic            rst_n,
  input  clpm_tag_t       tag_i,
  input  logic [PH_W-1:0] pa,
  input  logic [PH_W-1:0] pb,
  input  logic [PH_W-1:0] pc,
  input  logic [PH_W-1:0] pd,
  output clpm_tag_t       tag_o,
  output logic [15:0]     base
);

  clpm_tag_t t1_r, t2_r, t3_r, t4_r, t5_r;
  logic signed [15:0] s1_r, c1_r, s2_r, s3_r, s2b_r, s3b_r;
  logic signed [31:0] pr_r, pr_nxt;
  logic [33:0] u_nxt;
  logic [18:0] q_r, q2_r;
  logic [34:0] est_pr;
  logic [15:0] est_r;
  logic [19:0] rem_nxt;
  logic [15:0] base_r, base_nxt;

  always_ff @(posedge clk) begin
    t1_r <= tag_i;
    t2_r <= t1_r;
    t3_r <= t2_r;
    t4_r <= t3_r;
    t5_r <= t4_r;
    if (!rst_n) begin
      t1_r.vld <= 1'b0;
      t2_r.vld <= 1'b0;
      t3_r.vld <= 1'b0;
      t4_r.vld <= 1'b0;
      t5_r.vld <= 1'b0;
    end
  end

  assign pr_nxt = s1_r * c1_r;
  assign u_nxt  = {{2{pr_r[31]}}, pr_r}
                + {{4{s2b_r[15]}}, s2b_r, 14'b0}
                + {{5{s3b_r[15]}}, s3b_r, 13'b0}
                + WAVE_OFS;
  assign est_pr   = q_r * RECIP7;
  assign rem_nxt  = 20'(q2_r) - 20'(est_r) * 20'd7;
  assign base_nxt = (rem_nxt >= 20'd7) ? est_r + 16'd1 : est_r;

  always_ff @(posedge clk) begin
    s1_r   <= sine_of(pa);
    c1_r   <= sine_of(pb);
    s2_r   <= sine_of(pc);
    s3_r   <= sine_of(pd);
    pr_r   <= pr_nxt;
    s2b_r  <= s2_r;
    s3b_r  <= s3_r;
    q_r    <= u_nxt[31:13];
    est_r  <= est_pr[33:18];
    q2_r   <= q_r;
    base_r <= base_nxt;
  end

  assign tag_o = t5_r;
  assign base  = base_r;

  `CLPM_ASSERT_IMP(a_div7, t4_r.vld, rem_nxt < 20'd14)

endmodule

/* sv/clpm_power.sv */
// Base raised to the smoothness exponent through log2 and exp2, 36 register stages
`include "caustic_light_pixel_modulator_defines.svh"
module clpm_power import clpm_pkg::*; (
  input  logic                clk,
  input  logic                rst_n,
  input  clpm_tag_t           tag_i,
  input  logic [15:0]         base,
  input  logic [SMOOTH_W-1:0] smooth,
  output clpm_tag_t           tag_o,
  output logic [K_W-1:0]      k
);

  clpm_tag_t         lt_r [0:FRAC_W];
  logic [M_W-1:0]    sm_r [0:FRAC_W];
  logic [FRAC_W-1:0] fr_r [0:FRAC_W];
  logic [3:0]        lp_r [0:FRAC_W];
  logic              lz_r [0:FRAC_W];

  clpm_tag_t         et_r [0:FRAC_W];
  logic [M_W-1:0]    er_r [0:FRAC_W];
  logic [FRAC_W-1:0] ef_r [0:FRAC_W];
  logic [4:0]        ei_r [0:FRAC_W];
  logic              ez_r [0:FRAC_W];

  logic [3:0]        lead;
  logic [M_W-1:0]    m0_nxt;
  clpm_tag_t         gt_r, kt_r;
  logic [LG_W-1:0]   lg_r, lg_nxt;
  logic              gz_r;
  logic [LG_W+EXP_W-1:0] prod;
  logic [K_W-1:0]    k_r, k_nxt;
  logic [M_W-1:0]    kshift;

  always_comb begin
    lead = 4'd0;
    for (int i = 0; i < 16; i++) if (base[i]) lead = 4'(i);
  end
  assign m0_nxt = M_W'(base) << (5'd30 - {1'b0, lead});

  always_ff @(posedge clk) begin
    lt_r[0] <= tag_i;
    sm_r[0] <= m0_nxt;
    fr_r[0] <= '0;
    lp_r[0] <= lead;
    lz_r[0] <= (base == 16'd0);
    if (!rst_n) lt_r[0].vld <= 1'b0;
  end

  for (genvar s = 0; s < FRAC_W; s++) begin : g_log
    logic [2*M_W-1:0] sq;
    logic [M_W-1:0]   m_nxt;
    logic [FRAC_W-1:0] f_nxt;
    always_comb begin
      sq    = sm_r[s] * sm_r[s];
      m_nxt = sq[61] ? sq[61:31] : sq[60:30];
      f_nxt = fr_r[s];
      f_nxt[FRAC_W-1-s] = sq[61];
    end
    always_ff @(posedge clk) begin
      lt_r[s+1] <= lt_r[s];
      sm_r[s+1] <= m_nxt;
      fr_r[s+1] <= f_nxt;
      lp_r[s+1] <= lp_r[s];
      lz_r[s+1] <= lz_r[s];
      if (!rst_n) lt_r[s+1].vld <= 1'b0;
    end
  end

  assign lg_nxt = {5'd16 - {1'b0, lp_r[FRAC_W]}, 16'b0} - LG_W'(fr_r[FRAC_W]);

  always_ff @(posedge clk) begin
    gt_r <= lt_r[FRAC_W];
    lg_r <= lg_nxt;
    gz_r <= lz_r[FRAC_W];
    if (!rst_n) gt_r.vld <= 1'b0;
  end

  assign prod = (LG_W+EXP_W)'(lg_r) * (LG_W+EXP_W)'(EXP_TAB[smooth]);

  always_ff @(posedge clk) begin
    et_r[0] <= gt_r;
    er_r[0] <= ONE_Q30;
    ef_r[0] <= prod[31:16];
    ei_r[0] <= prod[36:32];
    ez_r[0] <= gz_r || (prod[38:32] >= 7'd17);
    if (!rst_n) et_r[0].vld <= 1'b0;
  end

  for (genvar s = 0; s < FRAC_W; s++) begin : g_exp
    logic [M_W+29:0] mp;
    logic [M_W-1:0]  r_nxt;
    always_comb begin
      mp    = er_r[s] * E2_TAB[s];
      r_nxt = ef_r[s][FRAC_W-1-s] ? mp[M_W+29:30] : er_r[s];
    end
    always_ff @(posedge clk) begin
      et_r[s+1] <= et_r[s];
      er_r[s+1] <= r_nxt;
      ef_r[s+1] <= ef_r[s];
      ei_r[s+1] <= ei_r[s];
      ez_r[s+1] <= ez_r[s];
      if (!rst_n) et_r[s+1].vld <= 1'b0;
    end
  end

  assign kshift = er_r[FRAC_W] >> (5'd14 + ei_r[FRAC_W]);
  assign k_nxt  = ez_r[FRAC_W] ? '0 : kshift[K_W-1:0];

  always_ff @(posedge clk) begin
    kt_r <= et_r[FRAC_W];
    k_r  <= k_nxt;
    if (!rst_n) kt_r.vld <= 1'b0;
  end

  assign tag_o = kt_r;
  assign k     = k_r;

  `CLPM_ASSERT_IMP(a_norm, lt_r[0].vld && !lz_r[0], sm_r[0][M_W-1])
  `CLPM_ASSERT_IMP(a_exp_bound, et_r[FRAC_W].vld, er_r[FRAC_W] <= ONE_Q30)

endmodule

/* dv/caustic_light_pixel_modulator_test.sv */
// Self-checking testbench of the caustic light pixel modulator: pixel stream against a predictor
`timescale 1ns / 100ps
module caustic_light_pixel_modulator_test;
  import clpm_pkg::*;

  typedef struct {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } shade_t;

  class caustic_scoreboard;
    logic [19:0] scale_x;
    logic [19:0] scale_y;
    logic [6:0]  smooth;
    logic [31:0] ftime;
    shade_t      pending[$];
    int          errors;
    int          checked;
    int          dark;
    int          sine_lut[1024];
    longint unsigned exp2_lut[16];

    function new();
      longint unsigned theta, pos, neg, term, v;
      int n, quad, rem, r;
      exp2_lut = '{759250125, 902905651, 984625594, 1028218693,
                   1050733751, 1062175491, 1067942999, 1070838486,
                   1072289173, 1073015252, 1073378477, 1073560135,
                   1073650976, 1073696399, 1073719111, 1073730468};
      for (int i = 0; i < 1024; i++) begin
        n = 4 * i;
        quad = n / 1024;
        rem = n % 1024;
        r = (quad % 2 == 1) ? 1024 - rem : rem;
        theta = (64'd1686629713 * r) / 1024;
        pos = theta;
        neg = 0;
        term = theta;
        for (int k = 1; k <= 8; k++) begin
          term = (term * theta) >> 30;
          term = (term * theta) >> 30;
          term = term / ((2 * k) * (2 * k + 1));
          if (k % 2 == 1) neg += term; else pos += term;
        end
        v = (pos > neg) ? pos - neg : 0;
        v = (v + 16384) >> 15;
        if (v > 32767) v = 32767;
        sine_lut[i] = (quad >= 2) ? -int'(v) : int'(v);
      end
      scale_x = RST_INV_SCALE;
      scale_y = RST_INV_SCALE;
      smooth = RST_SMOOTH;
      ftime = '0;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] data);
      case (idx)
        CFG_INV_X:  scale_x = data[19:0];
        CFG_INV_Y:  scale_y = data[19:0];
        CFG_SMOOTH: smooth = data[6:0];
        CFG_FTIME:  ftime = data;
        default: ;
      endcase
    endfunction

    function logic [23:0] wave_phase(longint unsigned scaled, longint unsigned k);
      longint unsigned prod;
      prod = (scaled * k) >> 20;
      return prod[23:0];
    endfunction

    function logic [23:0] drift(longint unsigned k);
      longint unsigned prod;
      prod = (longint'(ftime) * k) >> 16;
      return prod[23:0];
    endfunction

    function longint unsigned raise(longint unsigned base, longint unsigned ex);
      longint unsigned m, frac, lg, prod, ip, fp, r;
      int p;
      if (base == 0) return 0;
      p = 16;
      while (p > 0 && base[p] == 1'b0) p--;
      m = base << (30 - p);
      frac = 0;
      for (int b = 15; b >= 0; b--) begin
        m = (m * m) >> 30;
        if (m >= (64'd2 << 30)) begin
          frac |= 64'd1 << b;
          m >>= 1;
        end
      end
      lg = longint'(16 - p) * 65536 - frac;
      prod = (lg * ex) >> 16;
      ip = prod >> 16;
      fp = prod & 64'hFFFF;
      if (ip >= 17) return 0;
      r = 64'd1073741824;
      for (int b = 0; b < 16; b++)
        if (fp[15 - b]) r = (r * exp2_lut[b]) >> 30;
      return r >> (14 + ip);
    endfunction

    function logic [7:0] clamp(longint unsigned v);
      return (v > 255) ? 8'd255 : v[7:0];
    endfunction

    function void note(logic [11:0] x, logic [11:0] y, logic [7:0] r, logic [7:0] g,
                       logic [7:0] b);
      longint unsigned nx, ny, u, base, pct, ex, gain;
      logic [23:0] pa, pb, pc, pd;
      longint w;
      shade_t s;
      nx = longint'(x) * scale_x;
      ny = longint'(y) * scale_y;
      pa = wave_phase(nx, 5340354) + drift(1335088);
      pb = wave_phase(ny, 5340354) + drift(934562) + 24'h400000;
      pc = wave_phase(nx, 9879654) + wave_phase(ny, 6141407) + drift(1735615);
      pd = wave_phase(nx, 13617902) - wave_phase(ny, 10680707) + drift(2803686);
      w = longint'(sine_lut[pa[23:14]]) * sine_lut[pb[23:14]]
        + longint'(sine_lut[pc[23:14]]) * 16384 + longint'(sine_lut[pd[23:14]]) * 8192;
      u = w + 64'd1879048192;
      base = (u << 16) / 64'd3758096384;
      pct = (smooth > 100) ? 100 : smooth;
      ex = ((150 - pct) * 65536 + 25) / 50;
      gain = raise(base, ex);
      if (gain == 0) dark++;
      s.red = clamp((r * gain) >> 16);
      s.green = clamp((g * gain) >> 16);
      s.blue = clamp((b * gain * 72090) >> 32);
      pending.push_back(s);
    endfunction

    function void check(logic [7:0] r, logic [7:0] g, logic [7:0] b);
      shade_t s;
      if (pending.size() == 0) begin
        $display("%0t: unexpected result r=%0d g=%0d b=%0d", $time, r, g, b);
        errors++;
        return;
      end
      s = pending.pop_front();
      checked++;
      if (r !== s.red) begin
        $display("%0t: red expected %0d got %0d", $time, s.red, r);
        errors++;
      end
      if (g !== s.green) begin
        $display("%0t: green expected %0d got %0d", $time, s.green, g);
        errors++;
      end
      if (b !== s.blue) begin
        $display("%0t: blue expected %0d got %0d", $time, s.blue, b);
        errors++;
      end
    endfunction
  endclass

  localparam int SETTLE = TOTAL_LAT + 20;
  localparam int WATCHDOG = 5000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic [11:0] in_pix_x = '0;
  logic [11:0] in_pix_y = '0;
  logic [7:0] in_red = '0;
  logic [7:0] in_green = '0;
  logic [7:0] in_blue = '0;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_idx = '0;
  logic [CFG_W-1:0] cfg_wdata = '0;
  logic out_valid;
  logic [7:0] out_red;
  logic [7:0] out_green;
  logic [7:0] out_blue;

  caustic_scoreboard sb = new();
  int idle_cycles = 0;
  int sent = 0;
  int burst_left = 0;

  always #1 clk = ~clk;

  caustic_light_pixel_modulator DUT (
    .clk, .rst_n, .start, .busy, .in_pix_x, .in_pix_y, .in_red, .in_green, .in_blue,
    .cfg_we, .cfg_idx, .cfg_wdata, .out_valid, .out_red, .out_green, .out_blue
  );

  always @(posedge clk) begin
    if (rst_n && start && !busy) begin
      sb.note(in_pix_x, in_pix_y, in_red, in_green, in_blue);
      sent++;
    end
    if (rst_n && out_valid) sb.check(out_red, out_green, out_blue);
    if (rst_n && ((start && !busy) || out_valid)) idle_cycles = 0;
    else idle_cycles++;
    if (idle_cycles >= WATCHDOG) begin
      $display("%0t: watchdog expired", $time);
      $display("caustic_light_pixel_modulator_test failed");
      $finish;
    end
  end

  task automatic send_pixel(logic [11:0] x, logic [11:0] y, logic [7:0] r, logic [7:0] g,
                            logic [7:0] b);
    if (burst_left == 0) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
      burst_left = ($urandom_range(0, 3) == 0) ? 60 : $urandom_range(1, 20);
    end
    burst_left--;
    start <= 1'b1;
    in_pix_x <= x;
    in_pix_y <= y;
    in_red <= r;
    in_green <= g;
    in_blue <= b;
    do @(posedge clk); while (busy);
  endtask

  task automatic drain();
    start <= 1'b0;
    burst_left = 0;
    @(posedge clk);
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_cfg(logic [CFG_IDX_W-1:0] idx, logic [31:0] data);
    cfg_we <= 1'b1;
    cfg_idx <= idx;
    cfg_wdata <= data;
    @(posedge clk);
    sb.write_reg(idx, data);
    cfg_we <= 1'b0;
  endtask

  task automatic random_pixels(int n);
    for (int i = 0; i < n; i++)
      send_pixel($urandom, $urandom, $urandom, $urandom, $urandom);
  endtask

  initial begin
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_pixel(12'd0, 12'd0, 8'd0, 8'd0, 8'd0);
    send_pixel(12'd4095, 12'd4095, 8'd255, 8'd255, 8'd255);
    send_pixel(12'd0, 12'd4095, 8'd255, 8'd0, 8'd255);
    send_pixel(12'd4095, 12'd0, 8'd0, 8'd255, 8'd128);
    send_pixel(12'd2048, 12'd1024, 8'd1, 8'd128, 8'd254);
    drain();
    write_cfg(CFG_SMOOTH, 32'd0);
    write_cfg(CFG_INV_X, 32'd0);
    write_cfg(CFG_INV_Y, 32'hFFFFF);
    send_pixel(12'd4095, 12'd4095, 8'd255, 8'd255, 8'd255);
    send_pixel(12'd1, 12'd777, 8'd200, 8'd100, 8'd250);
    send_pixel(12'd3000, 12'd5, 8'd255, 8'd255, 8'd255);
    drain();
    write_cfg(CFG_SMOOTH, 32'd127);
    write_cfg(CFG_FTIME, 32'hFFFFFFFF);
    write_cfg(CFG_INV_X, 32'hFFFFF);
    write_cfg(CFG_INV_Y, 32'd0);
    write_cfg(4'd4, 32'hFFFFFFFF);
    write_cfg(4'd15, 32'd0);
    send_pixel(12'd4095, 12'd4095, 8'd255, 8'd255, 8'd255);
    send_pixel(12'd123, 12'd3210, 8'd255, 8'd0, 8'd255);
    send_pixel(12'd0, 12'd0, 8'd128, 8'd128, 8'd128);
    drain();
    write_cfg(CFG_SMOOTH, 32'd100);
    write_cfg(CFG_INV_X, 32'd1);
    write_cfg(CFG_INV_Y, 32'd1);
    write_cfg(CFG_FTIME, 32'h00010000);
    send_pixel(12'd4095, 12'd0, 8'd255, 8'd255, 8'd255);
    send_pixel(12'd0, 12'd4095, 8'd77, 8'd99, 8'd233);

    random_pixels(140);
    for (int ph = 0; ph < 7; ph++) begin
      drain();
      write_cfg(CFG_INV_X, (ph == 0) ? 32'hFFFFF : $urandom_range(0, 20'hFFFFF));
      write_cfg(CFG_INV_Y, (ph == 1) ? 32'd1 : $urandom_range(0, 20'hFFFFF));
      write_cfg(CFG_SMOOTH, (ph == 2) ? 32'd0 : (ph == 3) ? 32'd100 : $urandom_range(0, 127));
      write_cfg(CFG_FTIME, (ph == 4) ? 32'hFFFFFFFF : $urandom);
      if (ph == 5) write_cfg(4'($urandom_range(4, 15)), $urandom);
      random_pixels(115);
    end

    drain();
    if (sb.pending.size() != 0) begin
      $display("%0t: %0d results never arrived", $time, sb.pending.size());
      sb.errors++;
    end
    $display("Sent %0d pixels over eleven register settings, checked %0d results", sent,
             sb.checked);
    $display("%0d results had zero intensity, %0d field mismatches", sb.dark, sb.errors);
    if (sb.errors == 0) begin
      $display("caustic_light_pixel_modulator_test passed");
    end else begin
      $display("caustic_light_pixel_modulator_test failed");
    end
    $finish;
  end
endmodule
